// ===== design/amse_pkg.sv =====
// shared types, widths and register codes for the alpha mask span extractor
// no dependencies
`default_nettype none

package amse_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int DIM_W    = $clog2(MAX_DIM);
    localparam int DIM_CW   = $clog2(MAX_DIM + 1);
    localparam int CNT1_W   = DIM_W + 1;

    localparam int ALPHA_W  = 8;
    localparam int ORIGIN_W = 15;
    localparam int RECT_W   = 13;
    localparam int SPAN_X_W = 16;
    localparam int SPAN_Y_W = 16;
    localparam int SPAN_W_W = 13;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam int CMP_W = (RECT_W > DIM_CW) ? RECT_W : DIM_CW;
    localparam int SUM_W = ((ORIGIN_W > DIM_W) ? ORIGIN_W : DIM_W) + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X    = 2'd0,
        REG_ORIGIN_Y    = 2'd1,
        REG_RECT_WIDTH  = 2'd2,
        REG_RECT_HEIGHT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic [DIM_CW-1:0]   width_eff;
        logic [DIM_CW-1:0]   height_eff;
    } cfg_t;

    typedef struct packed {
        logic [SPAN_X_W-1:0] x;
        logic [SPAN_Y_W-1:0] y;
        logic [SPAN_W_W-1:0] width;
    } span_t;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [DIM_CW-1:0] clamp_dim(input logic [RECT_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext == '0)
        begin
            return DIM_CW'(1);
        end
        else if (ext > CMP_W'(MAX_DIM))
        begin
            return DIM_CW'(MAX_DIM);
        end
        else
        begin
            return DIM_CW'(ext);
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/alpha_mask_span_extractor.sv =====
// alpha mask span extractor: one alpha byte in per item, zero or one span out
// a span passes the pixel register and then the result register before it is shown
// throughput: one item per cycle; the pixel register stalls only while a span
// is waiting in the full result register
// reset: asynchronous active low; resets config, counters, run state, valid bits
// depends on amse_pkg, amse_cfg, amse_scan, amse_out
`default_nettype none

module alpha_mask_span_extractor (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [amse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [amse_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [amse_pkg::ALPHA_W-1:0]    alpha,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [amse_pkg::SPAN_X_W-1:0]        span_x,
    output logic [amse_pkg::SPAN_Y_W-1:0]        span_y,
    output logic [amse_pkg::SPAN_W_W-1:0]        span_width
);
    import amse_pkg::*;

    cfg_t  cfg;
    span_t span;
    logic  span_load;
    logic  out_free;

    amse_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    amse_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .alpha     (alpha),
        .out_free  (out_free),
        .span_load (span_load),
        .span      (span)
    );

    amse_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .span_load  (span_load),
        .span       (span),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .span_x     (span_x),
        .span_y     (span_y),
        .span_width (span_width)
    );

endmodule

`default_nettype wire

// ===== design/amse_cfg.sv =====
// configuration registers with size clamping
// depends on amse_pkg
`default_nettype none

module amse_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [amse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [amse_pkg::CFG_DATA_W-1:0] cfg_data,
    output amse_pkg::cfg_t                      cfg
);
    import amse_pkg::*;

    logic [ORIGIN_W-1:0] origin_x_reg;
    logic [ORIGIN_W-1:0] origin_y_reg;
    logic [RECT_W-1:0]   rect_width_reg;
    logic [RECT_W-1:0]   rect_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            rect_width_reg  <= RECT_W'(1);
            rect_height_reg <= RECT_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ORIGIN_X:    origin_x_reg    <= cfg_data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_data[ORIGIN_W-1:0];
                REG_RECT_WIDTH:  rect_width_reg  <= cfg_data[RECT_W-1:0];
                REG_RECT_HEIGHT: rect_height_reg <= cfg_data[RECT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg.origin_x   = origin_x_reg;
        cfg.origin_y   = origin_y_reg;
        cfg.width_eff  = clamp_dim(rect_width_reg);
        cfg.height_eff = clamp_dim(rect_height_reg);
    end

endmodule

`default_nettype wire

// ===== design/amse_scan.sv =====
// input register, column and row counters and per-pixel run detection
// depends on amse_pkg
`default_nettype none

module amse_scan (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire amse_pkg::cfg_t               cfg,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [amse_pkg::ALPHA_W-1:0] alpha,
    input  wire logic                         out_free,
    output logic                              span_load,
    output amse_pkg::span_t                   span
);
    import amse_pkg::*;

    logic               pix_valid_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [DIM_W-1:0]   column_reg;
    logic [DIM_W-1:0]   column_next;
    logic [DIM_W-1:0]   row_reg;
    logic [DIM_W-1:0]   row_next;
    logic               in_run_reg;
    logic               in_run_next;
    logic [DIM_W-1:0]   run_start_reg;
    logic [DIM_W-1:0]   run_start_next;

    logic               opaque;
    logic               last_col;
    logic               last_row;
    logic               emit;
    logic               consume;
    logic [DIM_W-1:0]   start;
    logic [CNT1_W-1:0]  col_plus1;
    logic [CNT1_W-1:0]  row_plus1;
    logic [CNT1_W-1:0]  run_end;
    logic [CNT1_W-1:0]  run_len;
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;

    always_comb
    begin
        opaque    = (alpha_reg != '0);
        col_plus1 = CNT1_W'(column_reg) + CNT1_W'(1);
        row_plus1 = CNT1_W'(row_reg) + CNT1_W'(1);
        last_col  = (col_plus1 >= CNT1_W'(cfg.width_eff));
        last_row  = (row_plus1 >= CNT1_W'(cfg.height_eff));
        start     = in_run_reg ? run_start_reg : column_reg;
        emit      = opaque ? last_col : in_run_reg;
        run_end   = opaque ? col_plus1 : CNT1_W'(column_reg);
        run_len   = run_end - CNT1_W'(start);
        sum_x     = SUM_W'(cfg.origin_x) + SUM_W'(start);
        sum_y     = SUM_W'(cfg.origin_y) + SUM_W'(row_reg);

        consume   = pix_valid_reg && (!emit || out_free);
        in_stall  = pix_valid_reg && !consume;
        span_load = pix_valid_reg && emit && out_free;

        span.x     = SPAN_X_W'(sum_x);
        span.y     = SPAN_Y_W'(sum_y);
        span.width = SPAN_W_W'(run_len);
    end

    always_comb
    begin
        column_next    = last_col ? '0 : col_plus1[DIM_W-1:0];
        row_next       = last_col ? (last_row ? '0 : row_plus1[DIM_W-1:0]) : row_reg;
        in_run_next    = opaque && !last_col;
        run_start_next = (opaque && !in_run_reg) ? column_reg : run_start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            column_reg    <= '0;
            row_reg       <= '0;
            in_run_reg    <= 1'b0;
            run_start_reg <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                pix_valid_reg <= in_valid;
            end
            if (consume)
            begin
                column_reg    <= column_next;
                row_reg       <= row_next;
                in_run_reg    <= in_run_next;
                run_start_reg <= run_start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            alpha_reg <= alpha;
        end
    end

endmodule

`default_nettype wire

// ===== design/amse_out.sv =====
// result register holding one span until it is taken
// depends on amse_pkg
`default_nettype none

module amse_out (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          span_load,
    input  wire amse_pkg::span_t               span,
    output logic                               out_free,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [amse_pkg::SPAN_X_W-1:0]      span_x,
    output logic [amse_pkg::SPAN_Y_W-1:0]      span_y,
    output logic [amse_pkg::SPAN_W_W-1:0]      span_width
);
    import amse_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    span_t span_reg;

    always_comb
    begin
        out_free   = !valid_reg || !out_stall;
        valid_next = span_load || (valid_reg && !out_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (span_load)
        begin
            span_reg <= span;
        end
    end

    assign out_valid  = valid_reg;
    assign span_x     = span_reg.x;
    assign span_y     = span_reg.y;
    assign span_width = span_reg.width;

endmodule

`default_nettype wire

// ===== design/amse_checker.sv =====
// port-level checks for the alpha mask span extractor, bound to the top level
// depends on amse_pkg
`default_nettype none

module amse_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [amse_pkg::SPAN_X_W-1:0]   span_x,
    input wire logic [amse_pkg::SPAN_Y_W-1:0]   span_y,
    input wire logic [amse_pkg::SPAN_W_W-1:0]   span_width
);
    import amse_pkg::*;

    // a held span stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("span dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(span_x) && $stable(span_y) && $stable(span_width))
        else $error("span changed while stalled");

    // every run holds at least one pixel
    a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> span_width != '0)
        else $error("empty span");

    // a fresh span follows an accepted item, through the pixel register and the result register
    a_span_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("span without an accepted item");

endmodule

bind alpha_mask_span_extractor amse_checker u_amse_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .span_x     (span_x),
    .span_y     (span_y),
    .span_width (span_width)
);

`default_nettype wire
